// ----- hdl/dls_pkg.sv -----
// ----------------------------------------------------------------------------
// dls_pkg
// Shared constants and types for the DDA line stepper.
// ----------------------------------------------------------------------------
package dls_pkg;

  localparam int unsigned COORD_BITS_DEF = 10;
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned QUEUE_DEPTH    = 2;

  typedef enum logic {
    OP_START = 1'b0,
    OP_NEXT  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_RUN = 3'b001,
    ST_DIV = 3'b010,
    ST_FIX = 3'b100
  } state_e;

endpackage

// ----- hdl/dls_front.sv -----
// ----------------------------------------------------------------------------
// dls_front
// Accepts requests, classifies them and computes the line deltas and the
// step count before pushing a command into the queue.
// ----------------------------------------------------------------------------
module dls_front #(
  parameter int unsigned COORD_BITS = dls_pkg::COORD_BITS_DEF,
  parameter int unsigned CMD_W      = 5 * COORD_BITS + 3
) (
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  op_i,
  input  logic [COORD_BITS-1:0] x_start_i,
  input  logic [COORD_BITS-1:0] y_start_i,
  input  logic [COORD_BITS-1:0] x_end_i,
  input  logic [COORD_BITS-1:0] y_end_i,
  input  logic                  q_full_i,
  output logic                  q_wr_o,
  output logic [CMD_W-1:0]      q_data_o
);

  typedef struct packed {
    dls_pkg::op_e          op;
    logic [COORD_BITS-1:0] xs;
    logic [COORD_BITS-1:0] ys;
    logic [COORD_BITS-1:0] adx;
    logic [COORD_BITS-1:0] ady;
    logic [COORD_BITS-1:0] steps;
    logic                  x_neg;
    logic                  y_neg;
  } cmd_t;

  cmd_t                  cmd;
  logic [COORD_BITS-1:0] max_d;

  always_comb begin
    cmd.op    = dls_pkg::op_e'(op_i);
    cmd.xs    = x_start_i;
    cmd.ys    = y_start_i;
    cmd.x_neg = x_end_i < x_start_i;
    cmd.y_neg = y_end_i < y_start_i;
    cmd.adx   = cmd.x_neg ? x_start_i - x_end_i : x_end_i - x_start_i;
    cmd.ady   = cmd.y_neg ? y_start_i - y_end_i : y_end_i - y_start_i;
    max_d     = (cmd.adx > cmd.ady) ? cmd.adx : cmd.ady;
    // zero-length line still takes one step
    cmd.steps = (max_d == '0) ? COORD_BITS'(1) : max_d;
  end

  assign in_stall_o = q_full_i;
  assign q_wr_o     = in_valid_i && !q_full_i;
  assign q_data_o   = cmd;

endmodule

// ----- hdl/dls_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// dls_cmd_fifo
// Short command queue between the front and the back end.
// ----------------------------------------------------------------------------
module dls_cmd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = dls_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             full_o,
  output logic             rd_valid_o,
  output logic [WIDTH-1:0] rd_data_o,
  input  logic             rd_pop_i
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o     = cnt_q == CNT_W'(DEPTH);
  assign rd_valid_o = cnt_q != '0;
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign do_wr      = wr_en_i && !full_o;
  assign do_rd      = rd_pop_i && rd_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ----- hdl/dls_back.sv -----
// ----------------------------------------------------------------------------
// dls_back
// Carries out queued commands: bit-serial increment division on a new line,
// one fixed-point step per next request, and the registered result stage.
// ----------------------------------------------------------------------------
module dls_back #(
  parameter int unsigned COORD_BITS = dls_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = dls_pkg::FRAC_BITS_DEF,
  parameter int unsigned CMD_W      = 5 * COORD_BITS + 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  input  logic [CMD_W-1:0]      cmd_i,
  output logic                  cmd_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COORD_BITS-1:0] px_o,
  output logic [COORD_BITS-1:0] py_o,
  output logic                  last_o,
  output logic                  idle_o
);

  localparam int unsigned POS_W = COORD_BITS + 1 + FRAC_BITS;
  localparam int unsigned CNT_W = $clog2(FRAC_BITS + 1);

  typedef struct packed {
    dls_pkg::op_e          op;
    logic [COORD_BITS-1:0] xs;
    logic [COORD_BITS-1:0] ys;
    logic [COORD_BITS-1:0] adx;
    logic [COORD_BITS-1:0] ady;
    logic [COORD_BITS-1:0] steps;
    logic                  x_neg;
    logic                  y_neg;
  } cmd_t;

  cmd_t                  cmd;
  dls_pkg::state_e       state_q, state_d;
  logic                  active_q, active_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_free, pop, is_start;

  // positions carry a built-in half so the output is a plain slice
  logic [POS_W-1:0]      posx_q, posy_q, incx_q, incy_q;
  logic [POS_W-1:0]      sumx, sumy;
  logic [COORD_BITS-1:0] left_q;
  logic [COORD_BITS:0]   rx_q, ry_q, rx_sh, ry_sh, rx_nx, ry_nx, div_s;
  logic [FRAC_BITS:0]    qx_q, qy_q;
  logic                  gex, gey, negx_q, negy_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [COORD_BITS-1:0] px_q, py_q;
  logic                  last_q, idle_q;

  assign cmd      = cmd_t'(cmd_i);
  assign out_free = !out_valid_q || !out_stall_i;
  assign pop      = (state_q == dls_pkg::ST_RUN) && cmd_valid_i && out_free;
  assign is_start = cmd.op == dls_pkg::OP_START;
  assign cmd_pop_o = pop;

  assign sumx = posx_q + incx_q;
  assign sumy = posy_q + incy_q;

  // restoring division, one quotient bit per cycle; left_q holds the divisor
  always_comb begin
    div_s = {1'b0, left_q};
    rx_sh = (cnt_q == '0) ? rx_q : {rx_q[COORD_BITS-1:0], 1'b0};
    ry_sh = (cnt_q == '0) ? ry_q : {ry_q[COORD_BITS-1:0], 1'b0};
    gex   = rx_sh >= div_s;
    gey   = ry_sh >= div_s;
    rx_nx = gex ? rx_sh - div_s : rx_sh;
    ry_nx = gey ? ry_sh - div_s : ry_sh;
  end

  always_comb begin
    state_d     = state_q;
    active_d    = active_q;
    out_valid_d = out_valid_q;
    if (pop) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      dls_pkg::ST_RUN: begin
        if (pop && is_start) begin
          state_d  = dls_pkg::ST_DIV;
          active_d = 1'b1;
        end else if (pop && active_q && left_q == COORD_BITS'(1)) begin
          active_d = 1'b0;
        end
      end
      dls_pkg::ST_DIV: begin
        if (cnt_q == CNT_W'(FRAC_BITS)) begin
          state_d = dls_pkg::ST_FIX;
        end
      end
      dls_pkg::ST_FIX: begin
        state_d = dls_pkg::ST_RUN;
      end
      default: begin
        state_d = dls_pkg::ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dls_pkg::ST_RUN;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      dls_pkg::ST_RUN: begin
        if (pop && is_start) begin
          posx_q <= (POS_W'(cmd.xs) << FRAC_BITS) | (POS_W'(1) << (FRAC_BITS - 1));
          posy_q <= (POS_W'(cmd.ys) << FRAC_BITS) | (POS_W'(1) << (FRAC_BITS - 1));
          left_q <= cmd.steps;
          rx_q   <= {1'b0, cmd.adx};
          ry_q   <= {1'b0, cmd.ady};
          negx_q <= cmd.x_neg;
          negy_q <= cmd.y_neg;
          qx_q   <= '0;
          qy_q   <= '0;
          cnt_q  <= '0;
        end else if (pop && active_q) begin
          posx_q <= sumx;
          posy_q <= sumy;
          left_q <= left_q - COORD_BITS'(1);
        end
      end
      dls_pkg::ST_DIV: begin
        rx_q  <= rx_nx;
        ry_q  <= ry_nx;
        qx_q  <= {qx_q[FRAC_BITS-1:0], gex};
        qy_q  <= {qy_q[FRAC_BITS-1:0], gey};
        cnt_q <= cnt_q + CNT_W'(1);
      end
      dls_pkg::ST_FIX: begin
        incx_q <= negx_q ? POS_W'(0) - POS_W'(qx_q) : POS_W'(qx_q);
        incy_q <= negy_q ? POS_W'(0) - POS_W'(qy_q) : POS_W'(qy_q);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (is_start) begin
        px_q   <= cmd.xs;
        py_q   <= cmd.ys;
        last_q <= 1'b0;
        idle_q <= 1'b0;
      end else if (active_q) begin
        px_q   <= sumx[FRAC_BITS +: COORD_BITS];
        py_q   <= sumy[FRAC_BITS +: COORD_BITS];
        last_q <= left_q == COORD_BITS'(1);
        idle_q <= 1'b0;
      end else begin
        px_q   <= '0;
        py_q   <= '0;
        last_q <= 1'b0;
        idle_q <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign px_o        = px_q;
  assign py_o        = py_q;
  assign last_o      = last_q;
  assign idle_o      = idle_q;

endmodule

// ----- hdl/dda_line_stepper.sv -----
// ----------------------------------------------------------------------------
// dda_line_stepper
// Fixed-point DDA line rasterizer with a decoupled command queue.
//
//   channel  handshake            payload
//   in       in_valid_i/in_stall_o  op_i x_start_i y_start_i x_end_i y_end_i
//   out      out_valid_o/out_stall_i px_o py_o last_o idle_o
//
// Next requests run at one per cycle unless the output stalls or a division
// runs; each goes through the queue and the result register. A start request
// emits its point at once, then the bit-serial divider holds the back end.
// Async active-low reset clears the queue, the back-end state and out valid.
// A stall on the output backs up into the queue and then into in_stall_o.
// ----------------------------------------------------------------------------
module dda_line_stepper #(
  parameter int unsigned COORD_BITS = dls_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = dls_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  op_i,
  input  logic [COORD_BITS-1:0] x_start_i,
  input  logic [COORD_BITS-1:0] y_start_i,
  input  logic [COORD_BITS-1:0] x_end_i,
  input  logic [COORD_BITS-1:0] y_end_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COORD_BITS-1:0] px_o,
  output logic [COORD_BITS-1:0] py_o,
  output logic                  last_o,
  output logic                  idle_o
);

  localparam int unsigned CMD_W = 5 * COORD_BITS + 3;

  logic             q_full, q_wr, q_valid, q_pop;
  logic [CMD_W-1:0] q_wdata, q_rdata;

  dls_front #(
    .COORD_BITS(COORD_BITS),
    .CMD_W     (CMD_W)
  ) u_front (
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .op_i      (op_i),
    .x_start_i (x_start_i),
    .y_start_i (y_start_i),
    .x_end_i   (x_end_i),
    .y_end_i   (y_end_i),
    .q_full_i  (q_full),
    .q_wr_o    (q_wr),
    .q_data_o  (q_wdata)
  );

  dls_cmd_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(dls_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (q_wr),
    .wr_data_i (q_wdata),
    .full_o    (q_full),
    .rd_valid_o(q_valid),
    .rd_data_o (q_rdata),
    .rd_pop_i  (q_pop)
  );

  dls_back #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS),
    .CMD_W     (CMD_W)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(q_valid),
    .cmd_i      (q_rdata),
    .cmd_pop_o  (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .px_o       (px_o),
    .py_o       (py_o),
    .last_o     (last_o),
    .idle_o     (idle_o)
  );

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && idle_o |-> px_o == '0 && py_o == '0)
    else $error("idle result carries a pixel");

  a_last_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(last_o && idle_o))
    else $error("result flagged both last and idle");

  a_queue_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> q_valid)
    else $error("accepted request missing from queue");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

endmodule

// ----- verif/dls_pixel_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dls_pixel_checker
// Watches both channels of the DDA line stepper. It keeps its own fixed-point
// line state, predicts the pixel for every accepted request, and compares each
// accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module dls_pixel_checker
  import dls_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic                      op_i,
  input  logic [COORD_BITS_DEF-1:0] x_start_i,
  input  logic [COORD_BITS_DEF-1:0] y_start_i,
  input  logic [COORD_BITS_DEF-1:0] x_end_i,
  input  logic [COORD_BITS_DEF-1:0] y_end_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic [COORD_BITS_DEF-1:0] px_i,
  input  logic [COORD_BITS_DEF-1:0] py_i,
  input  logic                      last_i,
  input  logic                      idle_i,
  output int unsigned               pending_o,
  output int unsigned               errors_o
);

  localparam int unsigned CB = COORD_BITS_DEF;
  localparam int unsigned FB = FRAC_BITS_DEF;

  typedef logic signed [CB+FB:0] fix_t;

  typedef struct packed {
    logic [CB-1:0] px;
    logic [CB-1:0] py;
    logic          last;
    logic          idle;
  } pixel_t;

  localparam fix_t HALF = fix_t'(1) << (FB - 1);

  fix_t          x_pos;
  fix_t          y_pos;
  fix_t          x_slope;
  fix_t          y_slope;
  logic [CB:0]   points_left;
  logic          line_on;
  pixel_t        expected_pixels[$];
  int unsigned   mismatches;

  // increment truncated toward zero
  function automatic fix_t slope_of(input logic [CB-1:0] from_c, input logic [CB-1:0] to_c,
                                    input logic [CB:0] steps);
    longint unsigned mag;
    longint unsigned quot;
    mag  = (to_c >= from_c) ? to_c - from_c : from_c - to_c;
    quot = (mag << FB) / steps;
    return (to_c >= from_c) ? fix_t'(quot) : -fix_t'(quot);
  endfunction

  function automatic logic [CB-1:0] rounded(input fix_t pos);
    fix_t r;
    r = pos + HALF;
    return r[FB +: CB];
  endfunction

  function automatic pixel_t step_line(input op_e op, input logic [CB-1:0] xs,
                                       input logic [CB-1:0] ys, input logic [CB-1:0] xe,
                                       input logic [CB-1:0] ye);
    pixel_t      p;
    logic [CB:0] adx;
    logic [CB:0] ady;
    logic [CB:0] steps;
    p = '0;
    if (op == OP_START) begin
      adx   = (xe >= xs) ? xe - xs : xs - xe;
      ady   = (ye >= ys) ? ye - ys : ys - ye;
      steps = (adx > ady) ? adx : ady;
      if (steps == '0) steps = {{CB{1'b0}}, 1'b1};
      x_slope     = slope_of(xs, xe, steps);
      y_slope     = slope_of(ys, ye, steps);
      x_pos       = {1'b0, xs, {FB{1'b0}}};
      y_pos       = {1'b0, ys, {FB{1'b0}}};
      points_left = steps;
      line_on     = 1'b1;
      p.px        = rounded(x_pos);
      p.py        = rounded(y_pos);
    end else if (!line_on) begin
      p.idle = 1'b1;
    end else begin
      x_pos       = x_pos + x_slope;
      y_pos       = y_pos + y_slope;
      points_left = points_left - 1'b1;
      p.px        = rounded(x_pos);
      p.py        = rounded(y_pos);
      if (points_left == '0) begin
        line_on = 1'b0;
        p.last  = 1'b1;
      end
    end
    return p;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t want;
    pixel_t got;
    if (!rst_ni) begin
      x_pos       = '0;
      y_pos       = '0;
      x_slope     = '0;
      y_slope     = '0;
      points_left = '0;
      line_on     = 1'b0;
      mismatches  = 0;
      expected_pixels.delete();
    end else begin
      // results first: a request accepted at this edge cannot be answered yet
      if (out_valid_i && !out_stall_i) begin
        got = '{px: px_i, py: py_i, last: last_i, idle: idle_i};
        if (expected_pixels.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result px=%0d py=%0d last=%b idle=%b", $time,
                   got.px, got.py, got.last, got.idle);
        end else begin
          want = expected_pixels.pop_front();
          if (got.px !== want.px || got.py !== want.py || got.last !== want.last ||
              got.idle !== want.idle) begin
            mismatches++;
            $display("%0t: mismatch expected px=%0d py=%0d last=%b idle=%b", $time,
                     want.px, want.py, want.last, want.idle);
            $display("%0t:          actual   px=%0d py=%0d last=%b idle=%b", $time,
                     got.px, got.py, got.last, got.idle);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_pixels.push_back(step_line(op_e'(op_i), x_start_i, y_start_i, x_end_i,
                                            y_end_i));
      end
    end
    pending_o <= expected_pixels.size();
    errors_o  <= mismatches;
  end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives line start and next-point requests into the DDA line stepper with
// random gaps and output stalls, one long output hold-off to back the block
// up, and a calm tail. The pixel checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import dls_pkg::*;

  localparam int unsigned CB             = COORD_BITS_DEF;
  localparam int unsigned FB             = FRAC_BITS_DEF;
  localparam int unsigned COORD_MAX      = (1 << CB) - 1;
  localparam int unsigned REQUEST_TOTAL  = 650;
  localparam int unsigned CALM_TAIL      = 100;
  localparam int unsigned HOLD_AT        = 150;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned CYCLE_LIMIT    = 400000;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_stall_o;
  logic          op_i;
  logic [CB-1:0] x_start_i;
  logic [CB-1:0] y_start_i;
  logic [CB-1:0] x_end_i;
  logic [CB-1:0] y_end_i;
  logic          out_valid_o;
  logic          out_stall_i;
  logic [CB-1:0] px_o;
  logic [CB-1:0] py_o;
  logic          last_o;
  logic          idle_o;

  int unsigned pending;
  int unsigned errors;
  int unsigned sent_count;
  int unsigned cycle_count;
  logic        quiet;
  logic        gaps_on;

  dda_line_stepper DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .x_start_i   (x_start_i),
    .y_start_i   (y_start_i),
    .x_end_i     (x_end_i),
    .y_end_i     (y_end_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .px_o        (px_o),
    .py_o        (py_o),
    .last_o      (last_o),
    .idle_o      (idle_o)
  );

  dls_pixel_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .op_i        (op_i),
    .x_start_i   (x_start_i),
    .y_start_i   (y_start_i),
    .x_end_i     (x_end_i),
    .y_end_i     (y_end_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .px_i        (px_o),
    .py_i        (py_o),
    .last_i      (last_o),
    .idle_i      (idle_o),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    wait (cycle_count >= CYCLE_LIMIT);
    $display("testbench NOT OK");
    $finish;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // output side: random stall bursts, one long hold-off, none in the tail
  initial begin
    logic held;
    held = 1'b0;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (!quiet && !held && sent_count >= HOLD_AT) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
      end
    end
  end

  task automatic offer(input op_e op, input logic [CB-1:0] xs, input logic [CB-1:0] ys,
                       input logic [CB-1:0] xe, input logic [CB-1:0] ye);
    if (!quiet && gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    x_start_i  <= xs;
    y_start_i  <= ys;
    x_end_i    <= xe;
    y_end_i    <= ye;
    do @(posedge clk_i); while (in_stall_o);
    sent_count++;
    if (sent_count >= REQUEST_TOTAL - CALM_TAIL) quiet = 1'b1;
  endtask

  // coordinate fields are don't-care on a next request, so they carry noise
  task automatic next_point();
    offer(OP_NEXT, CB'($urandom_range(0, COORD_MAX)), CB'($urandom_range(0, COORD_MAX)),
          CB'($urandom_range(0, COORD_MAX)), CB'($urandom_range(0, COORD_MAX)));
  endtask

  task automatic draw(input int xs, input int ys, input int xe, input int ye, input int nexts);
    offer(OP_START, CB'(xs), CB'(ys), CB'(xe), CB'(ye));
    repeat (nexts) next_point();
  endtask

  function automatic int far_end(input int c, input int d);
    int e;
    e = ($urandom_range(0, 1) == 1) ? c + d : c - d;
    if (e < 0 || e > int'(COORD_MAX)) e = 2 * c - e;
    if (e < 0) e = 0;
    if (e > int'(COORD_MAX)) e = COORD_MAX;
    return e;
  endfunction

  initial begin
    int xs, ys, xe, ye, major, minor, steps, nexts, pick;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    op_i        <= OP_START;
    x_start_i   <= '0;
    y_start_i   <= '0;
    x_end_i     <= '0;
    y_end_i     <= '0;
    sent_count  = 0;
    quiet       = 1'b0;
    gaps_on     = 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // next with no line, zero-length line, abandoned full-range diagonal,
    // opposite diagonal, steep line, negative-x line, half-way rounding
    next_point();
    draw(0, 0, 0, 0, 2);
    draw(COORD_MAX, COORD_MAX, 0, 0, 2);
    draw(0, COORD_MAX, COORD_MAX, 0, 1);
    draw(5, 5, 8, 12, 8);
    draw(10, 3, 7, 5, 3);
    draw(0, 0, 2, 1, 2);

    while (sent_count < REQUEST_TOTAL) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      pick    = $urandom_range(0, 19);
      if (pick == 0) begin
        next_point();
      end else begin
        if (pick < 13)      major = $urandom_range(0, 12);
        else if (pick < 17) major = $urandom_range(13, 80);
        else                major = $urandom_range(81, COORD_MAX);
        minor = $urandom_range(0, major);
        xs    = $urandom_range(0, COORD_MAX);
        ys    = $urandom_range(0, COORD_MAX);
        if ($urandom_range(0, 1) == 1) begin
          xe = far_end(xs, major);
          ye = far_end(ys, minor);
        end else begin
          xe = far_end(xs, minor);
          ye = far_end(ys, major);
        end
        steps = (xe > xs) ? xe - xs : xs - xe;
        if (((ye > ys) ? ye - ys : ys - ye) > steps) steps = (ye > ys) ? ye - ys : ys - ye;
        if (steps == 0) steps = 1;
        if (steps > 120)                      nexts = $urandom_range(0, 60);
        else if ($urandom_range(0, 6) == 0)   nexts = $urandom_range(0, steps - 1);
        else                                  nexts = steps + $urandom_range(0, 2);
        draw(xs, ys, xe, ye, nexts);
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (FB + 8) @(posedge clk_i);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ----- dda_line_stepper.f -----
hdl/dls_pkg.sv
hdl/dls_front.sv
hdl/dls_cmd_fifo.sv
hdl/dls_back.sv
hdl/dda_line_stepper.sv
verif/dls_pixel_checker.sv
verif/testbench.sv
